// File: hw/rtl/adfe_pkg.sv
// ============================================================================
// adfe_pkg
// Shared types and constants for the advertising data field extractor.
// ============================================================================
package adfe_pkg;

    localparam int unsigned NAME_CAP_DEFAULT = 128;

    localparam logic [7:0]  TYPE_NAME     = 8'h30;
    localparam logic [7:0]  TYPE_SVC16    = 8'h16;
    localparam logic [15:0] UUID_ID_SVC   = 16'h1852;
    localparam logic [15:0] UUID_FEAT_SVC = 16'h1856;
    localparam logic [7:0]  ENC_MASK      = 8'h01;

    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 40;

    typedef struct packed {
        logic [7:0] bytes_left;
        logic       frame_start;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic        report_valid;
        logic        encrypted;
        logic [7:0]  name_length;
        logic [23:0] bcast_id;
    } report_t;

    typedef struct packed {
        logic    emit;
        report_t report;
    } parse_out_t;

endpackage

// File: hw/rtl/adfe_parser.sv
// ============================================================================
// adfe_parser
// Length-type-value walker: holds the per-payload state and computes the
// summary for the byte being taken.
// ============================================================================
module adfe_parser
    import adfe_pkg::*;
#(
    parameter int unsigned NAME_CAP = NAME_CAP_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       take,
    input  item_t      item,
    output parse_out_t result
);

    typedef enum logic [1:0] {
        PH_LEN,
        PH_TYPE,
        PH_DATA
    } phase_t;

    localparam logic [7:0] CAP = NAME_CAP[7:0];

    phase_t      phase_reg, phase_next, phase_cur;
    logic [7:0]  left_reg, left_next, left_cur;
    logic [7:0]  offset_reg, offset_next, offset_cur;
    logic [7:0]  stype_reg, stype_next, stype_cur;
    logic [15:0] uuid_reg, uuid_next, uuid_cur;
    logic        stopped_reg, stopped_next, stopped_cur;
    logic [7:0]  name_reg, name_next, name_cur;
    logic [23:0] id_reg, id_next, id_cur;
    logic        found_reg, found_next, found_cur;
    logic        enc_reg, enc_next, enc_cur;

    logic [7:0]  dlen_type;
    logic [8:0]  dlen_data;
    logic [7:0]  left_dec;
    logic [7:0]  b;
    logic [7:0]  n;

    always_comb begin
        b = item.data_byte;
        n = item.bytes_left;

        phase_cur   = item.frame_start ? PH_LEN : phase_reg;
        left_cur    = item.frame_start ? 8'd0   : left_reg;
        offset_cur  = item.frame_start ? 8'd0   : offset_reg;
        stype_cur   = item.frame_start ? 8'd0   : stype_reg;
        uuid_cur    = item.frame_start ? 16'd0  : uuid_reg;
        stopped_cur = item.frame_start ? 1'b0   : stopped_reg;
        name_cur    = item.frame_start ? 8'd0   : name_reg;
        id_cur      = item.frame_start ? 24'd0  : id_reg;
        found_cur   = item.frame_start ? 1'b0   : found_reg;
        enc_cur     = item.frame_start ? 1'b0   : enc_reg;

        phase_next   = phase_cur;
        left_next    = left_cur;
        offset_next  = offset_cur;
        stype_next   = stype_cur;
        uuid_next    = uuid_cur;
        stopped_next = stopped_cur;
        name_next    = name_cur;
        id_next      = id_cur;
        found_next   = found_cur;
        enc_next     = enc_cur;

        dlen_type = left_cur - 8'd1;
        dlen_data = {1'b0, offset_cur} + {1'b0, left_cur};
        left_dec  = left_cur - 8'd1;

        if (!stopped_cur) begin
            case (phase_cur)
                PH_TYPE: begin
                    stype_next  = b;
                    offset_next = 8'd0;
                    uuid_next   = 16'd0;
                    left_next   = dlen_type;
                    if (b == TYPE_NAME && dlen_type != 8'd0) begin
                        name_next = (dlen_type > CAP) ? CAP : dlen_type;
                    end
                    phase_next = (dlen_type == 8'd0) ? PH_LEN : PH_DATA;
                end
                PH_DATA: begin
                    if (stype_cur == TYPE_SVC16 && dlen_data >= 9'd2) begin
                        if (offset_cur == 8'd0) begin
                            uuid_next = {8'd0, b};
                        end else if (offset_cur == 8'd1) begin
                            uuid_next = uuid_cur | {b, 8'd0};
                        end else if (uuid_cur == UUID_ID_SVC && dlen_data >= 9'd5
                                     && offset_cur <= 8'd4) begin
                            found_next = 1'b1;
                            case (offset_cur[2:0])
                                3'd2:    id_next[7:0]   = b;
                                3'd3:    id_next[15:8]  = b;
                                default: id_next[23:16] = b;
                            endcase
                        end else if (uuid_cur == UUID_FEAT_SVC && dlen_data >= 9'd3
                                     && offset_cur == 8'd2) begin
                            enc_next = |(b & ENC_MASK);
                        end
                    end
                    offset_next = offset_cur + 8'd1;
                    left_next   = left_dec;
                    if (left_dec == 8'd0) begin
                        phase_next = PH_LEN;
                    end
                end
                default: begin
                    if (n <= 8'd1 || b == 8'd0 || b > (n - 8'd1)) begin
                        stopped_next = 1'b1;
                        phase_next   = PH_LEN;
                    end else begin
                        left_next  = b;
                        phase_next = PH_TYPE;
                    end
                end
            endcase
        end

        result.emit                = (n == 8'd1);
        result.report.report_valid = found_next && (name_next != 8'd0);
        result.report.bcast_id     = result.report.report_valid ? id_next   : 24'd0;
        result.report.name_length  = result.report.report_valid ? name_next : 8'd0;
        result.report.encrypted    = result.report.report_valid ? enc_next  : 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_LEN;
            left_reg    <= 8'd0;
            offset_reg  <= 8'd0;
            stype_reg   <= 8'd0;
            uuid_reg    <= 16'd0;
            stopped_reg <= 1'b0;
            name_reg    <= 8'd0;
            id_reg      <= 24'd0;
            found_reg   <= 1'b0;
            enc_reg     <= 1'b0;
        end else if (take) begin
            phase_reg   <= phase_next;
            left_reg    <= left_next;
            offset_reg  <= offset_next;
            stype_reg   <= stype_next;
            uuid_reg    <= uuid_next;
            stopped_reg <= stopped_next;
            name_reg    <= name_next;
            id_reg      <= id_next;
            found_reg   <= found_next;
            enc_reg     <= enc_next;
        end
    end

endmodule

// File: hw/rtl/advertising_data_field_extractor_core.sv
// ============================================================================
// advertising_data_field_extractor_core
// Walks advertising payload structures byte by byte and emits one summary
// transaction on the last byte of each payload.
// ============================================================================
//  channel | dir | tdata (low bit up)                      | tuser
//  s_      | in  | data_byte[7:0], bytes_left[15:8]        | frame_start
//  m_      | out | bcast_id[23:0], name_length[31:24],     | report_valid
//          |     | encrypted[32], zero[39:33]              |
//
//  One byte per cycle sustained while the result register is not stalled; the
//  result register loads when the last byte of a payload advances out of the input register.
//  The parser state update between input and result registers sets the rate.
//  Reset (aresetn low, synchronous) clears the walk state and both stages.
//  A stalled result register holds the input stage; the input stage still
//  takes a transaction whenever it is empty or draining.
// ============================================================================
module advertising_data_field_extractor_core
    import adfe_pkg::*;
#(
    parameter int unsigned NAME_CAP = NAME_CAP_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // data_byte, bytes_left
    input  logic                   s_tuser,   // frame_start
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // bcast_id, name_length, encrypted, pad
    output logic                   m_tuser    // report_valid
);

    logic       in_valid_reg, in_valid_next;
    item_t      in_item_reg;
    logic       m_valid_reg, m_valid_next;
    report_t    m_report_reg;
    logic       advance;
    parse_out_t result;

    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (advance && result.emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.data_byte   <= s_tdata[7:0];
            in_item_reg.bytes_left  <= s_tdata[15:8];
            in_item_reg.frame_start <= s_tuser;
        end
        if (advance && result.emit) begin
            m_report_reg <= result.report;
        end
    end

    adfe_parser #(
        .NAME_CAP (NAME_CAP)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (advance),
        .item    (in_item_reg),
        .result  (result)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_report_reg.report_valid;
    assign m_tdata  = {7'd0, m_report_reg.encrypted, m_report_reg.name_length,
                       m_report_reg.bcast_id};

    a_last_byte_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_item_reg.bytes_left == 8'd1 |=> m_tvalid)
        else $error("last byte did not produce a result");

    a_ready_when_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with result register empty");

    a_name_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[31:24] != 8'd0 && m_tdata[31:24] <= NAME_CAP[7:0])
        else $error("reported name length out of range");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the advertising data field extractor. Streams
// payloads byte by byte: a few hand-built ones first, then random payloads
// made mostly of well-formed structures (name, broadcast ID service data,
// feature service data, other types), mixed with noise, corrupted bytes,
// missing frame starts and bad byte counts. A scoreboard tracks the walk
// state and checks every summary transaction against its own prediction.
// ============================================================================
module tb_top
    import adfe_pkg::*;
();

    localparam int unsigned TOTAL_ITEMS = 1850;
    localparam int unsigned CALM_TAIL   = 200;
    localparam int unsigned NAME_LIMIT  = NAME_CAP_DEFAULT;

    typedef enum logic [1:0] {
        AT_LENGTH,
        AT_TYPE,
        AT_DATA
    } walk_phase_t;

    class adv_scoreboard_t;
        walk_phase_t phase;
        logic [7:0]  seg_left;
        logic [7:0]  seg_offset;
        logic [7:0]  seg_type;
        logic [15:0] svc_uuid;
        logic        stopped;
        logic [7:0]  name_len;
        logic [23:0] bid;
        logic        bid_found;
        logic        enc;

        report_t     expected_q[$];
        int unsigned n_items;
        int unsigned n_reports;
        int unsigned n_valid;
        int unsigned n_fail;

        function new();
            restart();
            n_items   = 0;
            n_reports = 0;
            n_valid   = 0;
            n_fail    = 0;
        endfunction

        function void restart();
            phase      = AT_LENGTH;
            seg_left   = '0;
            seg_offset = '0;
            seg_type   = '0;
            svc_uuid   = '0;
            stopped    = 1'b0;
            name_len   = '0;
            bid        = '0;
            bid_found  = 1'b0;
            enc        = 1'b0;
        endfunction

        function void walk_byte(logic [7:0] b, logic [7:0] left);
            logic [7:0]  dlen;
            int unsigned k;
            int unsigned span;
            if (!stopped) begin
                case (phase)
                    AT_TYPE: begin
                        dlen       = seg_left - 8'd1;
                        seg_type   = b;
                        seg_offset = '0;
                        svc_uuid   = '0;
                        seg_left   = dlen;
                        if (b == TYPE_NAME && dlen != 0)
                            name_len = (dlen > NAME_LIMIT) ? NAME_LIMIT[7:0] : dlen;
                        phase = (dlen == 0) ? AT_LENGTH : AT_DATA;
                    end
                    AT_DATA: begin
                        k    = seg_offset;
                        span = int'(seg_offset) + int'(seg_left);
                        if (seg_type == TYPE_SVC16 && span >= 2) begin
                            if (k == 0) begin
                                svc_uuid = {8'h00, b};
                            end else if (k == 1) begin
                                svc_uuid[15:8] = b;
                            end else if (svc_uuid == UUID_ID_SVC && span >= 5 && k <= 4) begin
                                bid[(k-2)*8 +: 8] = b;
                                bid_found = 1'b1;
                            end else if (svc_uuid == UUID_FEAT_SVC && span >= 3 && k == 2) begin
                                enc = |(b & ENC_MASK);
                            end
                        end
                        seg_offset = seg_offset + 8'd1;
                        seg_left   = seg_left - 8'd1;
                        if (seg_left == 0)
                            phase = AT_LENGTH;
                    end
                    default: begin
                        if (left <= 1 || b == 0 || b > left - 8'd1) begin
                            stopped = 1'b1;
                            phase   = AT_LENGTH;
                        end else begin
                            seg_left = b;
                            phase    = AT_TYPE;
                        end
                    end
                endcase
            end
        endfunction

        function void note_byte(logic [7:0] b, logic st, logic [7:0] left);
            report_t want;
            n_items++;
            if (st)
                restart();
            walk_byte(b, left);
            if (left == 8'd1) begin
                want = '0;
                if (bid_found && name_len != 0) begin
                    want.report_valid = 1'b1;
                    want.bcast_id     = bid;
                    want.name_length  = name_len;
                    want.encrypted    = enc;
                end
                expected_q.push_back(want);
            end
        endfunction

        function void compare(string what, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                n_fail++;
                $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
            end
        endfunction

        function void check_summary(logic [OUT_TDATA_W-1:0] tdata, logic tuser);
            report_t want;
            if (expected_q.size() == 0) begin
                n_fail++;
                $display("%0t: unexpected summary: expected none, actual tdata=%h tuser=%b",
                         $time, tdata, tuser);
            end else begin
                want = expected_q.pop_front();
                n_reports++;
                if (want.report_valid)
                    n_valid++;
                compare("report_valid", 32'(want.report_valid), 32'(tuser));
                compare("bcast_id", 32'(want.bcast_id), 32'(tdata[23:0]));
                compare("name_length", 32'(want.name_length), 32'(tdata[31:24]));
                compare("encrypted", 32'(want.encrypted), 32'(tdata[32]));
                compare("pad", 32'd0, 32'(tdata[OUT_TDATA_W-1:33]));
            end
        endfunction
    endclass

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tuser  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b1;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;

    adv_scoreboard_t sb = new();
    logic [7:0]      payload_q[$];
    int unsigned     items_sent = 0;
    bit              calm       = 1'b0;

    advertising_data_field_extractor_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // data_byte, bytes_left
        .s_tuser  (s_tuser),   // frame_start
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // bcast_id, name_length, encrypted, pad
        .m_tuser  (m_tuser)    // report_valid
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_byte(s_tdata[7:0], s_tuser, s_tdata[15:8]);
        if (aresetn && m_tvalid && m_tready)
            sb.check_summary(m_tdata, m_tuser);
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_item(input logic [7:0] b, input logic st, input logic [7:0] left);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {left, b};
        s_tuser  <= st;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_payload(input bit drop_start, input bit skew_left);
        int n;
        int skew_at;
        int left;
        n       = payload_q.size();
        skew_at = skew_left ? int'($urandom_range(0, n - 1)) : -1;
        for (int i = 0; i < n; i++) begin
            left = n - i;
            if (i == skew_at)
                left = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 255));
            send_item(payload_q[i], (i == 0) && !drop_start, left[7:0]);
        end
    endtask

    task automatic push_struct(input logic [7:0] ad_type, input int dlen,
                               input logic [15:0] uuid, input bit with_uuid);
        payload_q.push_back(8'(dlen + 1));
        payload_q.push_back(ad_type);
        for (int j = 0; j < dlen; j++) begin
            if (with_uuid && j == 0)
                payload_q.push_back(uuid[7:0]);
            else if (with_uuid && j == 1)
                payload_q.push_back(uuid[15:8]);
            else
                payload_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic make_payload();
        int target;
        int room;
        int max_d;
        int dlen;
        int pick;
        logic [15:0] uuid;
        payload_q.delete();
        target = ($urandom_range(0, 19) == 0) ? int'($urandom_range(120, 255))
                                              : int'($urandom_range(1, 40));
        if ($urandom_range(0, 14) == 0) begin
            repeat (target) payload_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            if (target >= 120 && $urandom_range(0, 1) == 1)
                push_struct(TYPE_NAME, $urandom_range(100, target - 2), 16'h0, 1'b0);
            while (payload_q.size() < target) begin
                room  = target - payload_q.size();
                max_d = room - 2;
                pick  = $urandom_range(0, 15);
                if (room < 3) begin
                    payload_q.push_back(8'($urandom_range(0, 255)));
                end else if (pick <= 2) begin
                    dlen = $urandom_range(0, (max_d < 12) ? max_d : 12);
                    push_struct(TYPE_NAME, dlen, 16'h0, 1'b0);
                end else if (pick <= 6) begin
                    dlen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4)
                                                       : $urandom_range(5, 8);
                    if (dlen > max_d)
                        dlen = max_d;
                    uuid = UUID_ID_SVC;
                    if ($urandom_range(0, 7) == 0)
                        uuid = uuid ^ (16'h1 << $urandom_range(0, 15));
                    push_struct(TYPE_SVC16, dlen, uuid, 1'b1);
                end else if (pick <= 9) begin
                    dlen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2)
                                                       : $urandom_range(3, 6);
                    if (dlen > max_d)
                        dlen = max_d;
                    push_struct(TYPE_SVC16, dlen, UUID_FEAT_SVC, 1'b1);
                end else if (pick <= 11) begin
                    dlen = $urandom_range(0, (max_d < 10) ? max_d : 10);
                    push_struct(8'($urandom_range(0, 255)), dlen,
                                16'($urandom_range(0, 65535)), 1'b1);
                end else if (pick == 12) begin
                    push_struct(8'($urandom_range(0, 255)), 0, 16'h0, 1'b0);
                end else if (pick == 13) begin
                    payload_q.push_back(8'h00);
                end else if (pick == 14) begin
                    payload_q.push_back(8'($urandom_range(room, 255)));
                end else begin
                    payload_q.push_back(8'($urandom_range(0, 255)));
                end
            end
            if ($urandom_range(0, 7) == 0)
                payload_q[$urandom_range(0, payload_q.size() - 1)] = 8'($urandom_range(0, 255));
        end
    endtask

    initial begin
        int waited;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // name plus broadcast ID with extreme bytes
        payload_q = '{8'h02, TYPE_NAME, 8'h41,
                      8'h06, TYPE_SVC16, UUID_ID_SVC[7:0], UUID_ID_SVC[15:8],
                      8'hFF, 8'h00, 8'hFF};
        send_payload(1'b0, 1'b0);
        // feature bit, empty structure, zero length stop
        payload_q = '{8'h04, TYPE_SVC16, UUID_FEAT_SVC[7:0], UUID_FEAT_SVC[15:8], 8'hFF,
                      8'h01, 8'hFF, 8'h00, 8'h5A};
        send_payload(1'b0, 1'b0);
        // single-byte payload
        payload_q = '{8'h00};
        send_payload(1'b0, 1'b0);
        // zero byte count
        send_item(8'h07, 1'b1, 8'h00);
        // length past the end
        payload_q = '{8'hFF, TYPE_NAME};
        send_payload(1'b0, 1'b0);
        // continue a stopped walk without frame start
        payload_q = '{8'h02, TYPE_NAME, 8'h41};
        send_payload(1'b1, 1'b0);

        while (items_sent < TOTAL_ITEMS) begin
            calm = (items_sent + CALM_TAIL >= TOTAL_ITEMS) || ($urandom_range(0, 3) == 0);
            make_payload();
            send_payload($urandom_range(0, 11) == 0, $urandom_range(0, 19) == 0);
        end
        calm = 1'b1;

        s_tvalid <= 1'b0;
        @(posedge aclk);
        for (waited = 0; sb.expected_q.size() != 0 && waited < 5000; waited++)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (sb.expected_q.size() != 0) begin
            $display("%0t: %0d summaries never arrived", $time, sb.expected_q.size());
            sb.n_fail += sb.expected_q.size();
        end

        $display("Streamed %0d payload bytes; checked %0d summaries, %0d of them valid.",
                 sb.n_items, sb.n_reports, sb.n_valid);
        $display("Mismatches found: %0d", sb.n_fail);
        if (sb.n_fail == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/adfe_pkg.sv
hw/rtl/adfe_parser.sv
hw/rtl/advertising_data_field_extractor_core.sv
tb/tb_top.sv
